[hw/rtl/lec_pkg.sv]
// Shared types, constants and helpers of the local extrema counter.
`timescale 1ns / 1ps

package lec_pkg;

  // Default build sizes
  localparam int MAX_COLS_DEFAULT    = 512;
  localparam int MAX_ROWS_DEFAULT    = 512;
  localparam int SAMPLE_BITS_DEFAULT = 16;

  // Configuration port
  localparam int CFG_INDEX_W = 2;
  localparam int CFG_DATA_W  = 10;
  localparam int DIM_RESET   = 512;

  localparam logic [CFG_INDEX_W-1:0] REG_FRAME_ROWS = CFG_INDEX_W'(0);
  localparam logic [CFG_INDEX_W-1:0] REG_FRAME_COLS = CFG_INDEX_W'(1);

  // Result widths
  localparam int CNT_W     = 19;
  localparam int EXT_CNT_W = 20;

  // Candidate flags: bit 0 still a minimum, bit 1 still a maximum
  typedef logic [1:0] flag_t;
  localparam int    FLAG_MIN_BIT = 0;
  localparam int    FLAG_MAX_BIT = 1;
  localparam flag_t FLAGS_BOTH   = 2'b11;

  // Position of the sample held in the compare stage
  typedef struct packed {
    logic valid;
    logic first_col;
    logic first_row;
    logic last_col;
    logic last_row;
  } stage_ctl_t;

  // Clear the candidate flags that a comparison takes away
  function automatic flag_t drop_flags(input flag_t f, input logic lost_min,
                                       input logic lost_max);
    flag_t m;
    m = '0;
    m[FLAG_MIN_BIT] = lost_min;
    m[FLAG_MAX_BIT] = lost_max;
    return f & ~m;
  endfunction

endpackage

[hw/rtl/lec_sample_if.sv]
// Sample request channel.
`timescale 1ns / 1ps

interface lec_sample_if #(
  parameter int SAMPLE_BITS = lec_pkg::SAMPLE_BITS_DEFAULT
);
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] sample;

  modport source (output valid, output sample, input ready);
  modport sink   (input valid, input sample, output ready);
endinterface

[hw/rtl/lec_result_if.sv]
// Result request channel carrying the per-frame counts.
`timescale 1ns / 1ps

interface lec_result_if;
  logic                           valid;
  logic                           ready;
  logic [lec_pkg::CNT_W-1:0]      minima_count;
  logic [lec_pkg::CNT_W-1:0]      maxima_count;
  logic [lec_pkg::EXT_CNT_W-1:0]  extrema_count;

  modport source (output valid, output minima_count, output maxima_count,
                  output extrema_count, input ready);
  modport sink   (input valid, input minima_count, input maxima_count,
                  input extrema_count, output ready);
endinterface

[hw/rtl/lec_cfg_if.sv]
// Configuration write channel.
`timescale 1ns / 1ps

interface lec_cfg_if;
  logic                             valid;
  logic                             ready;
  logic [lec_pkg::CFG_INDEX_W-1:0]  index;
  logic [lec_pkg::CFG_DATA_W-1:0]   data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

[hw/rtl/lec_line_mem.sv]
// Previous-row line store: one write port, one registered read port.
`timescale 1ns / 1ps

module lec_line_mem #(
  parameter int WIDTH = 18,
  parameter int DEPTH = 512
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Read port, write-first on a same-address collision
  always_ff @(posedge clk) begin
    if (re) begin
      if (we && (waddr == raddr)) begin
        rdata <= wdata;
      end else begin
        rdata <= mem[raddr];
      end
    end
  end

endmodule

[hw/rtl/lec_ctrl.sv]
// Front end: frame registers, raster position, input handshake, line reads.
`timescale 1ns / 1ps

module lec_ctrl #(
  parameter int MAX_COLS    = lec_pkg::MAX_COLS_DEFAULT,
  parameter int MAX_ROWS    = lec_pkg::MAX_ROWS_DEFAULT,
  parameter int SAMPLE_BITS = lec_pkg::SAMPLE_BITS_DEFAULT
) (
  input  logic                          clk,
  input  logic                          rst_n,
  lec_sample_if.sink                    in_ch,
  lec_cfg_if.sink                       cfg_ch,
  input  logic                          out_valid,
  input  logic                          out_ready,
  output lec_pkg::stage_ctl_t           stage_r,
  output logic [$clog2(MAX_COLS)-1:0]   b_col_r,
  output logic signed [SAMPLE_BITS-1:0] b_x_r,
  output logic                          rd_en,
  output logic [$clog2(MAX_COLS)-1:0]   rd_addr,
  output logic                          restart
);

  localparam int COL_W = $clog2(MAX_COLS);
  localparam int ROW_W = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
  localparam int COL_RESET_LAST =
    ((lec_pkg::DIM_RESET > MAX_COLS) ? MAX_COLS : lec_pkg::DIM_RESET) - 1;
  localparam int ROW_RESET_LAST =
    ((lec_pkg::DIM_RESET > MAX_ROWS) ? MAX_ROWS : lec_pkg::DIM_RESET) - 1;

  // Zero acts as one, oversize saturates; store the last index
  function automatic logic [COL_W-1:0] col_last(
    input logic [lec_pkg::CFG_DATA_W-1:0] v
  );
    int unsigned n;
    n = 32'(v);
    if (n == 0) n = 1;
    if (n > MAX_COLS) n = MAX_COLS;
    return COL_W'(n - 1);
  endfunction

  function automatic logic [ROW_W-1:0] row_last(
    input logic [lec_pkg::CFG_DATA_W-1:0] v
  );
    int unsigned n;
    n = 32'(v);
    if (n == 0) n = 1;
    if (n > MAX_ROWS) n = MAX_ROWS;
    return ROW_W'(n - 1);
  endfunction

  logic [COL_W-1:0] col_r;
  logic [ROW_W-1:0] row_r;
  logic [COL_W-1:0] last_col_idx_r;
  logic [ROW_W-1:0] last_row_idx_r;

  logic in_ready;
  logic accept;
  logic cfg_write;
  logic at_last_col;
  logic at_last_row;
  logic next_final;
  logic out_blocked;
  logic stage_final;

  assign at_last_col = (col_r == last_col_idx_r);
  assign at_last_row = (row_r == last_row_idx_r);
  assign next_final  = at_last_col && at_last_row;

  // A frame-ending sample needs the output register free by the time it reaches the compare stage
  assign out_blocked = out_valid && !out_ready;
  assign stage_final = stage_r.valid && stage_r.last_row && stage_r.last_col;
  assign in_ready    = !next_final || (!out_blocked && !stage_final);
  assign in_ch.ready = in_ready;
  assign accept      = in_ch.valid && in_ready;

  assign cfg_ch.ready = 1'b1;
  assign cfg_write    = cfg_ch.valid;
  assign restart      = cfg_write && ((cfg_ch.index == lec_pkg::REG_FRAME_ROWS) ||
                                      (cfg_ch.index == lec_pkg::REG_FRAME_COLS));

  // Fetch the upper-right neighbour for the arriving sample
  assign rd_en   = accept;
  assign rd_addr = col_r + COL_W'(1);

  // Frame registers and raster position
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_col_idx_r <= COL_W'(COL_RESET_LAST);
      last_row_idx_r <= ROW_W'(ROW_RESET_LAST);
      col_r          <= '0;
      row_r          <= '0;
      stage_r        <= '0;
    end else begin
      stage_r.valid <= accept;
      if (cfg_write) begin
        unique case (cfg_ch.index)
          lec_pkg::REG_FRAME_ROWS: begin
            last_row_idx_r <= row_last(cfg_ch.data);
            col_r          <= '0;
            row_r          <= '0;
          end
          lec_pkg::REG_FRAME_COLS: begin
            last_col_idx_r <= col_last(cfg_ch.data);
            col_r          <= '0;
            row_r          <= '0;
          end
          default: begin
          end
        endcase
      end else if (accept) begin
        stage_r.first_col <= (col_r == '0);
        stage_r.first_row <= (row_r == '0);
        stage_r.last_col  <= at_last_col;
        stage_r.last_row  <= at_last_row;
        if (at_last_col) begin
          col_r <= '0;
          row_r <= at_last_row ? '0 : row_r + ROW_W'(1);
        end else begin
          col_r <= col_r + COL_W'(1);
        end
      end
    end
  end

  // Sample and column of the compare stage
  always_ff @(posedge clk) begin
    if (accept) begin
      b_col_r <= col_r;
      b_x_r   <= in_ch.sample;
    end
  end

endmodule

[hw/rtl/lec_datapath.sv]
// Compare stage: neighbour compares, flag updates, line write-back, counts.
`timescale 1ns / 1ps

module lec_datapath #(
  parameter int MAX_COLS    = lec_pkg::MAX_COLS_DEFAULT,
  parameter int SAMPLE_BITS = lec_pkg::SAMPLE_BITS_DEFAULT
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  lec_pkg::stage_ctl_t           stage,
  input  logic [$clog2(MAX_COLS)-1:0]   b_col,
  input  logic signed [SAMPLE_BITS-1:0] b_x,
  input  logic                          restart,
  input  logic [SAMPLE_BITS+1:0]        rd_data,
  output logic                          mem_we,
  output logic [$clog2(MAX_COLS)-1:0]   mem_waddr,
  output logic [SAMPLE_BITS+1:0]        mem_wdata,
  output logic                          out_valid,
  lec_result_if.source                  out_ch
);

  localparam int COL_W = $clog2(MAX_COLS);
  localparam int CNT_W = lec_pkg::CNT_W;
  localparam int EXT_W = lec_pkg::EXT_CNT_W;

  // Window around the current sample
  logic signed [SAMPLE_BITS-1:0] left_s_r, ul_s_r, up_s_r, row0_s_r, tail_s_r;
  lec_pkg::flag_t                left_f_r, ul_f_r, up_f_r, row0_f_r, tail_f_r;
  logic                          tail_pend_r;
  logic [COL_W-1:0]              tail_addr_r;

  logic [CNT_W-1:0] min_tot_r, max_tot_r;
  logic [EXT_W-1:0] ext_tot_r;
  logic             out_valid_r;
  logic [CNT_W-1:0] out_min_r, out_max_r;
  logic [EXT_W-1:0] out_ext_r;

  logic signed [SAMPLE_BITS-1:0] u0_s, u1_s;
  lec_pkg::flag_t                u0_f, u1_f;
  lec_pkg::flag_t                fx, left_fn, ul_fn, u0_fn, u1_fn;
  logic                          tail_hit;
  logic en_left, en_ul, en_u0, en_u1;
  logic lt_left, lt_ul, lt_u0, lt_u1;
  logic gt_left, gt_ul, gt_u0, gt_u1;
  logic fin_ul, fin_u0, fin_left, fin_x;
  logic [2:0] inc_min, inc_max;
  logic [CNT_W-1:0] min_sum, max_sum;
  logic [EXT_W-1:0] ext_sum;
  logic frame_end;

  // Neighbour selection: entry 0 is kept in a register, pending tail forwarded
  assign tail_hit = tail_pend_r && (tail_addr_r == (b_col + COL_W'(1)));
  assign u0_s = stage.first_col ? row0_s_r : up_s_r;
  assign u0_f = stage.first_col ? row0_f_r : up_f_r;
  assign u1_s = tail_hit ? tail_s_r : SAMPLE_BITS'(rd_data[SAMPLE_BITS+1:2]);
  assign u1_f = tail_hit ? tail_f_r : rd_data[1:0];

  // In-frame neighbours seen so far
  assign en_left = !stage.first_col;
  assign en_ul   = !stage.first_row && !stage.first_col;
  assign en_u0   = !stage.first_row;
  assign en_u1   = !stage.first_row && !stage.last_col;

  assign lt_left = left_s_r < b_x;
  assign gt_left = left_s_r > b_x;
  assign lt_ul   = ul_s_r < b_x;
  assign gt_ul   = ul_s_r > b_x;
  assign lt_u0   = u0_s < b_x;
  assign gt_u0   = u0_s > b_x;
  assign lt_u1   = u1_s < b_x;
  assign gt_u1   = u1_s > b_x;

  // Flag updates on both sides of each comparison
  always_comb begin
    fx = lec_pkg::drop_flags(lec_pkg::FLAGS_BOTH,
           (en_left && lt_left) || (en_ul && lt_ul) || (en_u0 && lt_u0) ||
           (en_u1 && lt_u1),
           (en_left && gt_left) || (en_ul && gt_ul) || (en_u0 && gt_u0) ||
           (en_u1 && gt_u1));
    left_fn = en_left ? lec_pkg::drop_flags(left_f_r, gt_left, lt_left) : left_f_r;
    ul_fn   = en_ul   ? lec_pkg::drop_flags(ul_f_r, gt_ul, lt_ul)       : ul_f_r;
    u0_fn   = en_u0   ? lec_pkg::drop_flags(u0_f, gt_u0, lt_u0)         : u0_f;
    u1_fn   = en_u1   ? lec_pkg::drop_flags(u1_f, gt_u1, lt_u1)         : u1_f;
  end

  // Pixels whose last neighbour has now arrived
  assign fin_ul   = en_ul;
  assign fin_u0   = !stage.first_row && stage.last_col;
  assign fin_left = stage.last_row && !stage.first_col;
  assign fin_x    = stage.last_row && stage.last_col;

  assign inc_min = {2'b00, fin_ul   && ul_fn[lec_pkg::FLAG_MIN_BIT]} +
                   {2'b00, fin_u0   && u0_fn[lec_pkg::FLAG_MIN_BIT]} +
                   {2'b00, fin_left && left_fn[lec_pkg::FLAG_MIN_BIT]} +
                   {2'b00, fin_x    && fx[lec_pkg::FLAG_MIN_BIT]};
  assign inc_max = {2'b00, fin_ul   && ul_fn[lec_pkg::FLAG_MAX_BIT]} +
                   {2'b00, fin_u0   && u0_fn[lec_pkg::FLAG_MAX_BIT]} +
                   {2'b00, fin_left && left_fn[lec_pkg::FLAG_MAX_BIT]} +
                   {2'b00, fin_x    && fx[lec_pkg::FLAG_MAX_BIT]};

  assign min_sum   = min_tot_r + CNT_W'(inc_min);
  assign max_sum   = max_tot_r + CNT_W'(inc_max);
  assign ext_sum   = ext_tot_r + EXT_W'(inc_min) + EXT_W'(inc_max);
  assign frame_end = stage.valid && stage.last_row && stage.last_col;

  // Line write-back: the row-end entry is held as a pending tail and written after the rest
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = tail_addr_r;
    mem_wdata = {tail_s_r, tail_f_r};
    if (tail_pend_r) begin
      mem_we = 1'b1;
    end else if (stage.valid && !stage.first_col) begin
      mem_we    = 1'b1;
      mem_waddr = b_col - COL_W'(1);
      mem_wdata = {left_s_r, left_fn};
    end
  end

  // Control state, running totals and result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tail_pend_r <= 1'b0;
      out_valid_r <= 1'b0;
      min_tot_r   <= '0;
      max_tot_r   <= '0;
      ext_tot_r   <= '0;
      left_s_r    <= '0;
      left_f_r    <= lec_pkg::FLAGS_BOTH;
      ul_s_r      <= '0;
      ul_f_r      <= lec_pkg::FLAGS_BOTH;
    end else begin
      tail_pend_r <= stage.valid && stage.last_col && !restart;
      if (frame_end) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
      if (restart || frame_end) begin
        min_tot_r <= '0;
        max_tot_r <= '0;
        ext_tot_r <= '0;
        left_s_r  <= '0;
        left_f_r  <= lec_pkg::FLAGS_BOTH;
        ul_s_r    <= '0;
        ul_f_r    <= lec_pkg::FLAGS_BOTH;
      end else if (stage.valid) begin
        min_tot_r <= min_sum;
        max_tot_r <= max_sum;
        ext_tot_r <= ext_sum;
        ul_s_r    <= u0_s;
        ul_f_r    <= u0_fn;
        if (!stage.last_col) begin
          left_s_r <= b_x;
          left_f_r <= fx;
        end
      end
    end
  end

  // Window payload: carried upper entry, entry 0, row-end entry, results
  always_ff @(posedge clk) begin
    if (stage.valid) begin
      if (stage.last_col) begin
        tail_addr_r <= b_col;
        tail_s_r    <= b_x;
        tail_f_r    <= fx;
        if (stage.first_col) begin
          row0_s_r <= b_x;
          row0_f_r <= fx;
        end
      end else begin
        up_s_r <= u1_s;
        up_f_r <= u1_fn;
      end
      if (b_col == COL_W'(1)) begin
        row0_s_r <= left_s_r;
        row0_f_r <= left_fn;
      end
    end
    if (frame_end) begin
      out_min_r <= min_sum;
      out_max_r <= max_sum;
      out_ext_r <= ext_sum;
    end
  end

  assign out_valid            = out_valid_r;
  assign out_ch.valid         = out_valid_r;
  assign out_ch.minima_count  = out_min_r;
  assign out_ch.maxima_count  = out_max_r;
  assign out_ch.extrema_count = out_ext_r;

endmodule

[hw/rtl/local_extrema_counter_3x3.sv]
// The counts of a frame are loaded into the output register from its last sample's compare stage.
// Throughput: one sample per cycle; a frame-ending sample waits while the single
// output register still holds the previous frame's counts.
// Each sample does one line-store read and one write; the write of a row's last
// entry trails in a tail register and is forwarded. Reset clears control and counts;
// the line store is not cleared and needs no sweep, the block is ready at once.
`timescale 1ns / 1ps

module local_extrema_counter_3x3 #(
  parameter int MAX_COLS    = lec_pkg::MAX_COLS_DEFAULT,
  parameter int MAX_ROWS    = lec_pkg::MAX_ROWS_DEFAULT,
  parameter int SAMPLE_BITS = lec_pkg::SAMPLE_BITS_DEFAULT
) (
  input  logic          clk,
  input  logic          rst_n,
  lec_sample_if.sink    in_ch,
  lec_result_if.source  out_ch,
  lec_cfg_if.sink       cfg_ch
);

  localparam int COL_W = $clog2(MAX_COLS);
  localparam int ENT_W = SAMPLE_BITS + 2;

  lec_pkg::stage_ctl_t           stage;
  logic [COL_W-1:0]              b_col;
  logic signed [SAMPLE_BITS-1:0] b_x;
  logic                          rd_en;
  logic [COL_W-1:0]              rd_addr;
  logic [ENT_W-1:0]              rd_data;
  logic                          restart;
  logic                          mem_we;
  logic [COL_W-1:0]              mem_waddr;
  logic [ENT_W-1:0]              mem_wdata;
  logic                          out_valid;

  // Frame position and input handshake
  lec_ctrl #(
    .MAX_COLS    (MAX_COLS),
    .MAX_ROWS    (MAX_ROWS),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .cfg_ch    (cfg_ch),
    .out_valid (out_valid),
    .out_ready (out_ch.ready),
    .stage_r   (stage),
    .b_col_r   (b_col),
    .b_x_r     (b_x),
    .rd_en     (rd_en),
    .rd_addr   (rd_addr),
    .restart   (restart)
  );

  // Previous row with candidate flags
  lec_line_mem #(
    .WIDTH (ENT_W),
    .DEPTH (MAX_COLS)
  ) u_line_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (rd_en),
    .raddr (rd_addr),
    .rdata (rd_data)
  );

  // Compare, update and count
  lec_datapath #(
    .MAX_COLS    (MAX_COLS),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_datapath (
    .clk       (clk),
    .rst_n     (rst_n),
    .stage     (stage),
    .b_col     (b_col),
    .b_x       (b_x),
    .restart   (restart),
    .rd_data   (rd_data),
    .mem_we    (mem_we),
    .mem_waddr (mem_waddr),
    .mem_wdata (mem_wdata),
    .out_valid (out_valid),
    .out_ch    (out_ch)
  );

endmodule
